// ===== sv/tsl_pkg.sv =====
// Shared types, codes and keyword tables for the tagged string-list parser.
// No dependencies; imported by tsl_core, tsl_resq and tagged_string_list_parser.
package tsl_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int LINE_BITS_DEF  = 24;

  // Most results one text byte can cause.
  localparam int MAX_RES  = 2;

  // Result queue sizing.
  localparam int Q_DEPTH  = 8;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_LVL_W  = $clog2(Q_DEPTH + 1);

  // Lexer modes.
  localparam logic [2:0] LM_NORMAL  = 3'd0;
  localparam logic [2:0] LM_COMMENT = 3'd1;
  localparam logic [2:0] LM_KEYWORD = 3'd2;
  localparam logic [2:0] LM_NUMBER  = 3'd3;
  localparam logic [2:0] LM_STRING  = 3'd4;
  localparam logic [2:0] LM_ESCAPE  = 3'd5;

  // Grammar states.
  localparam logic [2:0] GS_HEAD       = 3'd0;
  localparam logic [2:0] GS_AFTER_HEAD = 3'd1;
  localparam logic [2:0] GS_NAME       = 3'd2;
  localparam logic [2:0] GS_COUNT      = 3'd3;
  localparam logic [2:0] GS_VALUES     = 3'd4;

  // Tokens handed from the lexer to the grammar.
  localparam logic [2:0] TK_EOI   = 3'd0;
  localparam logic [2:0] TK_TAG   = 3'd1;
  localparam logic [2:0] TK_ARRAY = 3'd2;
  localparam logic [2:0] TK_OVR   = 3'd3;
  localparam logic [2:0] TK_INT   = 3'd4;
  localparam logic [2:0] TK_OPEN  = 3'd5;
  localparam logic [2:0] TK_CLOSE = 3'd6;

  // Result kinds.
  localparam logic [2:0] K_START     = 3'd0;
  localparam logic [2:0] K_NAME_B    = 3'd1;
  localparam logic [2:0] K_NAME_END  = 3'd2;
  localparam logic [2:0] K_VAL_B     = 3'd3;
  localparam logic [2:0] K_VAL_END   = 3'd4;
  localparam logic [2:0] K_GROUP_END = 3'd5;
  localparam logic [2:0] K_EOI       = 3'd6;
  localparam logic [2:0] K_ERR       = 3'd7;

  // Error codes.
  localparam logic [2:0] E_BAD_CHAR  = 3'd0;
  localparam logic [2:0] E_BAD_ESC   = 3'd1;
  localparam logic [2:0] E_PREMATURE = 3'd2;
  localparam logic [2:0] E_EXP_HEAD  = 3'd3;
  localparam logic [2:0] E_EXP_STR   = 3'd4;
  localparam logic [2:0] E_EXP_INT   = 3'd5;
  localparam logic [2:0] E_MISMATCH  = 3'd6;
  localparam logic [2:0] E_TOO_LARGE = 3'd7;

  // Characters.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        is_array;
    logic        is_override;
    logic [15:0] value_count;
    logic [2:0]  error_code;
    logic [23:0] line_number;
    logic        last;
  } res_t;

  // Results produced by one byte, in order.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Keyword spelling: 0 TAG, 1 ARRAY, 2 OVERRIDE.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (k)
      2'd0: begin
        case (pos)
          3'd0:    c = 8'h54; // T
          3'd1:    c = 8'h41; // A
          3'd2:    c = 8'h47; // G
          default: c = CH_NUL;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0:    c = 8'h41; // A
          3'd1:    c = 8'h52; // R
          3'd2:    c = 8'h52; // R
          3'd3:    c = 8'h41; // A
          3'd4:    c = 8'h59; // Y
          default: c = CH_NUL;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0:    c = 8'h4F; // O
          3'd1:    c = 8'h56; // V
          3'd2:    c = 8'h45; // E
          3'd3:    c = 8'h52; // R
          3'd4:    c = 8'h52; // R
          3'd5:    c = 8'h49; // I
          3'd6:    c = 8'h44; // D
          default: c = 8'h45; // E
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] l;
    case (k)
      2'd0:    l = 4'd3;
      2'd1:    l = 4'd5;
      default: l = 4'd8;
    endcase
    return l;
  endfunction

  function automatic logic [2:0] kw_tok(input logic [1:0] k);
    logic [2:0] t;
    case (k)
      2'd0:    t = TK_TAG;
      2'd1:    t = TK_ARRAY;
      default: t = TK_OVR;
    endcase
    return t;
  endfunction

  // Keyword selected by its first letter (T, A or O).
  function automatic logic [1:0] kw_first(input logic [7:0] b);
    logic [1:0] k;
    case (b)
      CH_T:    k = 2'd0;
      CH_A:    k = 2'd1;
      default: k = 2'd2;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/tsl_core.sv =====
// Lexer and group grammar: one text byte per cycle, up to two results out.
// Depends on tsl_pkg.
module tsl_core #(
  parameter int COUNT_BITS = tsl_pkg::COUNT_BITS_DEF,
  parameter int LINE_BITS  = tsl_pkg::LINE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_vld,
  input  logic [7:0]     byte_in,
  output tsl_pkg::push_t push
);
  import tsl_pkg::*;

  typedef struct packed {
    logic [2:0]            gs;
    logic                  is_array;
    logic                  ovr;
    logic [COUNT_BITS-1:0] decl;
    logic [COUNT_BITS:0]   seen;
  } gst_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       e0;
    res_t       e1;
  } evs_t;

  typedef struct packed {
    gst_t s;
    evs_t ev;
    logic halt;
    logic clr;
  } gout_t;

  localparam logic [COUNT_BITS:0]   CAP   = (COUNT_BITS+1)'(1) << COUNT_BITS;
  localparam logic [COUNT_BITS+4:0] CAP_W = (COUNT_BITS+5)'(1) << COUNT_BITS;
  localparam logic [LINE_BITS-1:0]  LINE_ONE = LINE_BITS'(1);
  localparam gst_t GST_CLR = {GS_HEAD, 1'b0, 1'b0, {COUNT_BITS{1'b0}},
                              {(COUNT_BITS+1){1'b0}}};

  logic [2:0]            mode_r, mode_nxt;
  logic [1:0]            k_r, k_nxt;
  logic [2:0]            pos_r, pos_nxt;
  logic [COUNT_BITS:0]   num_r, num_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt;
  gst_t                  gst_r, gst_nxt;
  logic                  halted_r, halted_nxt;

  function automatic evs_t add_ev(input evs_t a, input res_t e);
    evs_t o;
    o = a;
    if (a.n == 2'd0) begin
      o.e0 = e;
      o.n  = 2'd1;
    end else if (a.n == 2'd1) begin
      o.e1 = e;
      o.n  = 2'd2;
    end
    return o;
  endfunction

  function automatic res_t mk_ev(input logic [2:0] kind, input logic [7:0] data,
                                 input logic arr, input logic ovr,
                                 input logic [15:0] cnt, input logic [2:0] err);
    res_t r;
    r             = '0;
    r.kind        = kind;
    r.data_byte   = data;
    r.is_array    = arr;
    r.is_override = ovr;
    r.value_count = cnt;
    r.error_code  = err;
    return r;
  endfunction

  function automatic gout_t fail(input gout_t gi, input logic [2:0] code);
    gout_t o;
    o      = gi;
    o.ev   = add_ev(gi.ev, mk_ev(K_ERR, 8'd0, 1'b0, 1'b0, 16'd0, code));
    o.halt = 1'b1;
    return o;
  endfunction

  function automatic gout_t g_head(input gout_t gi, input logic [2:0] tok);
    gout_t o;
    o = gi;
    if (tok == TK_EOI) begin
      o.ev  = add_ev(gi.ev, mk_ev(K_EOI, 8'd0, 1'b0, 1'b0, 16'd0, 3'd0));
      o.clr = 1'b1;
    end else if (tok == TK_TAG || tok == TK_ARRAY) begin
      o.s.is_array = (tok == TK_ARRAY);
      o.s.ovr      = 1'b0;
      o.s.decl     = '0;
      o.s.seen     = '0;
      o.s.gs       = GS_AFTER_HEAD;
    end else if (tok != TK_OPEN) begin
      o = fail(gi, E_EXP_HEAD);
    end
    return o;
  endfunction

  function automatic gout_t gram(input gout_t gi, input logic [2:0] tok,
                                 input logic [COUNT_BITS:0] val);
    gout_t                  o;
    logic [COUNT_BITS+16:0] wide;
    logic [15:0]            cnt;
    o    = gi;
    wide = (COUNT_BITS+17)'(gi.s.seen);
    cnt  = (wide > (COUNT_BITS+17)'(16'hFFFF)) ? 16'hFFFF : wide[15:0];
    case (gi.s.gs)
      GS_HEAD: o = g_head(gi, tok);
      GS_AFTER_HEAD, GS_NAME: begin
        if (tok == TK_OVR && gi.s.gs == GS_AFTER_HEAD) begin
          o.s.ovr = 1'b1;
          o.s.gs  = GS_NAME;
        end else if (tok == TK_OPEN) begin
          o.ev = add_ev(gi.ev, mk_ev(K_START, 8'd0, gi.s.is_array, gi.s.ovr, 16'd0, 3'd0));
        end else if (tok == TK_CLOSE) begin
          o.ev   = add_ev(gi.ev, mk_ev(K_NAME_END, 8'd0, 1'b0, 1'b0, 16'd0, 3'd0));
          o.s.gs = gi.s.is_array ? GS_COUNT : GS_VALUES;
        end else begin
          o = fail(gi, E_EXP_STR);
        end
      end
      GS_COUNT: begin
        if (tok == TK_INT) begin
          // Value saturates at the cap, so its top bit flags an oversize count.
          if (val[COUNT_BITS]) begin
            o = fail(gi, E_TOO_LARGE);
          end else begin
            o.s.decl = val[COUNT_BITS-1:0];
            o.s.gs   = GS_VALUES;
          end
        end else if (tok != TK_OPEN) begin
          o = fail(gi, E_EXP_INT);
        end
      end
      default: begin
        if (tok == TK_OPEN) begin
          o = gi;
        end else if (tok == TK_CLOSE) begin
          if (!gi.s.seen[COUNT_BITS]) begin
            o.s.seen = gi.s.seen + 1'b1;
          end
          o.ev = add_ev(gi.ev, mk_ev(K_VAL_END, 8'd0, 1'b0, 1'b0, 16'd0, 3'd0));
        end else if (gi.s.is_array && {1'b0, gi.s.decl} != gi.s.seen) begin
          o = fail(gi, E_MISMATCH);
        end else begin
          // Close the group, then read this token as the next head.
          o.ev   = add_ev(gi.ev, mk_ev(K_GROUP_END, 8'd0, 1'b0, 1'b0, cnt, 3'd0));
          o.s.gs = GS_HEAD;
          o      = g_head(o, tok);
        end
      end
    endcase
    return o;
  endfunction

  function automatic gout_t str_byte(input gout_t gi, input logic [7:0] b);
    gout_t o;
    o = gi;
    if (gi.s.gs == GS_AFTER_HEAD || gi.s.gs == GS_NAME) begin
      o.ev = add_ev(gi.ev, mk_ev(K_NAME_B, b, 1'b0, 1'b0, 16'd0, 3'd0));
    end else if (gi.s.gs == GS_VALUES) begin
      o.ev = add_ev(gi.ev, mk_ev(K_VAL_B, b, 1'b0, 1'b0, 16'd0, 3'd0));
    end
    return o;
  endfunction

  gout_t                  g;
  logic [LINE_BITS-1:0]   line_inc;
  logic [LINE_BITS+23:0]  line_w;

  always_comb begin
    logic [COUNT_BITS+4:0] acc;
    logic [3:0]            d;
    logic [3:0]            pos_inc;
    logic                  is_dig;
    logic                  run_n;
    logic                  inc;

    g.s      = gst_r;
    g.ev     = '0;
    g.halt   = 1'b0;
    g.clr    = 1'b0;
    mode_nxt = mode_r;
    k_nxt    = k_r;
    pos_nxt  = pos_r;
    num_nxt  = num_r;
    run_n    = 1'b0;
    inc      = 1'b0;
    d        = byte_in[3:0];
    is_dig   = byte_in inside {[CH_0:CH_9]};
    pos_inc  = {1'b0, pos_r} + 4'd1;
    acc      = ({4'b0, num_r} << 3) + ({4'b0, num_r} << 1) + (COUNT_BITS+5)'(d);

    if (byte_vld && !halted_r) begin
      case (mode_r)
        LM_NUMBER: begin
          if (is_dig) begin
            num_nxt = (acc > CAP_W) ? CAP : acc[COUNT_BITS:0];
          end else begin
            // Count ends here; the byte is then lexed as usual.
            mode_nxt = LM_NORMAL;
            g        = gram(g, TK_INT, num_r);
            num_nxt  = '0;
            run_n    = !g.halt;
          end
        end
        LM_COMMENT: begin
          if (byte_in inside {CH_CR, CH_LF, CH_NUL}) begin
            mode_nxt = LM_NORMAL;
            run_n    = 1'b1;
          end
        end
        LM_KEYWORD: begin
          if (k_r == 2'd3 || byte_in != kw_char(k_r, pos_r)) begin
            g = fail(g, E_BAD_CHAR);
          end else if (pos_inc >= kw_len(k_r)) begin
            mode_nxt = LM_NORMAL;
            k_nxt    = 2'd0;
            pos_nxt  = 3'd0;
            g        = gram(g, kw_tok(k_r), '0);
          end else begin
            pos_nxt = pos_inc[2:0];
          end
        end
        LM_STRING: begin
          if (byte_in == CH_QUOTE) begin
            mode_nxt = LM_NORMAL;
            g        = gram(g, TK_CLOSE, '0);
          end else if (byte_in == CH_NUL) begin
            g = fail(g, E_PREMATURE);
          end else if (byte_in == CH_BSLASH) begin
            mode_nxt = LM_ESCAPE;
          end else begin
            inc = (byte_in == CH_LF);
            g   = str_byte(g, byte_in);
          end
        end
        LM_ESCAPE: begin
          mode_nxt = LM_STRING;
          if (byte_in == CH_LC_N) begin
            g = str_byte(g, CH_LF);
          end else if (byte_in == CH_LC_T) begin
            g = str_byte(g, CH_TAB);
          end else if (byte_in inside {CH_BSLASH, CH_QUOTE, CH_SQUOTE}) begin
            g = str_byte(g, byte_in);
          end else if (byte_in == CH_NUL) begin
            g = fail(g, E_PREMATURE);
          end else begin
            g = fail(g, E_BAD_ESC);
          end
        end
        default: begin
          mode_nxt = LM_NORMAL;
          run_n    = 1'b1;
        end
      endcase

      if (run_n) begin
        if (byte_in == CH_NUL) begin
          g = gram(g, TK_EOI, '0);
        end else if (byte_in inside {CH_SP, CH_TAB, CH_CR}) begin
          mode_nxt = LM_NORMAL;
        end else if (byte_in inside {CH_HASH, CH_STAR}) begin
          mode_nxt = LM_COMMENT;
        end else if (byte_in == CH_LF) begin
          inc = 1'b1;
        end else if (is_dig) begin
          mode_nxt = LM_NUMBER;
          num_nxt  = (COUNT_BITS+1)'(d);
        end else if (byte_in == CH_QUOTE) begin
          mode_nxt = LM_STRING;
          g        = gram(g, TK_OPEN, '0);
        end else if (byte_in inside {CH_T, CH_A, CH_O}) begin
          mode_nxt = LM_KEYWORD;
          k_nxt    = kw_first(byte_in);
          pos_nxt  = 3'd1;
        end else begin
          g = fail(g, E_BAD_CHAR);
        end
      end
    end

    // A newline always counts before any result of the same byte.
    line_inc = (inc && line_r != '1) ? line_r + LINE_ONE : line_r;
    line_w   = (LINE_BITS+24)'(line_inc);

    if (g.clr) begin
      mode_nxt     = LM_NORMAL;
      k_nxt        = 2'd0;
      pos_nxt      = 3'd0;
      num_nxt      = '0;
      line_nxt     = LINE_ONE;
      gst_nxt      = GST_CLR;
      halted_nxt   = 1'b0;
    end else begin
      line_nxt   = line_inc;
      gst_nxt    = g.s;
      halted_nxt = halted_r | g.halt;
    end

    push                = '0;
    push.n              = g.ev.n;
    push.r0             = g.ev.e0;
    push.r0.line_number = line_w[23:0];
    push.r0.last        = (g.ev.n == 2'd1);
    push.r1             = g.ev.e1;
    push.r1.line_number = line_w[23:0];
    push.r1.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= LM_NORMAL;
      k_r         <= 2'd0;
      pos_r       <= 3'd0;
      num_r       <= '0;
      line_r      <= LINE_ONE;
      gst_r       <= GST_CLR;
      halted_r    <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      k_r         <= k_nxt;
      pos_r       <= pos_nxt;
      num_r       <= num_nxt;
      line_r      <= line_nxt;
      gst_r       <= gst_nxt;
      halted_r    <= halted_nxt;
    end
  end

endmodule

// ===== sv/tsl_resq.sv =====
// Result queue: takes up to two results a cycle, hands out one per transfer.
// Depends on tsl_pkg.
module tsl_resq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tsl_pkg::push_t               push,
  input  logic                         pop_stall,
  output logic                         out_vld,
  output tsl_pkg::res_t                out_res,
  output logic [tsl_pkg::Q_LVL_W-1:0]  level
);
  import tsl_pkg::*;

  res_t                mem [Q_DEPTH];
  res_t                head_r;
  logic                head_vld_r, head_vld_nxt;
  logic [Q_PTR_W-1:0]  wr_r, wr_nxt;
  logic [Q_PTR_W-1:0]  rd_r, rd_nxt;
  logic [Q_LVL_W-1:0]  cnt_r, cnt_nxt;
  logic [Q_PTR_W-1:0]  wr_p1;
  logic [1:0]          n_store;
  logic                pop;
  logic                load;
  logic                from_mem;
  logic                bypass;

  // The head sits in an output register; mem holds the results behind it.
  assign out_vld  = head_vld_r;
  assign out_res  = head_r;
  assign level    = cnt_r + Q_LVL_W'(head_vld_r);
  assign pop      = head_vld_r && !pop_stall;
  assign load     = !head_vld_r || pop;
  assign from_mem = load && (cnt_r != '0);
  assign bypass   = load && (cnt_r == '0) && (push.n != 2'd0);
  assign wr_p1    = wr_r + Q_PTR_W'(1);

  always_comb begin
    n_store      = bypass ? push.n - 2'd1 : push.n;
    wr_nxt       = wr_r + Q_PTR_W'(n_store);
    rd_nxt       = from_mem ? rd_r + Q_PTR_W'(1) : rd_r;
    cnt_nxt      = cnt_r + Q_LVL_W'(n_store) - Q_LVL_W'(from_mem);
    head_vld_nxt = load ? (from_mem || bypass) : head_vld_r;
  end

  always_ff @(posedge clk) begin
    if (bypass) begin
      if (push.n == 2'd2) begin
        mem[wr_r] <= push.r1;
      end
    end else begin
      if (push.n != 2'd0) begin
        mem[wr_r] <= push.r0;
      end
      if (push.n == 2'd2) begin
        mem[wr_p1] <= push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (from_mem) begin
      head_r <= mem[rd_r];
    end else if (bypass) begin
      head_r <= push.r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r       <= '0;
      rd_r       <= '0;
      cnt_r      <= '0;
      head_vld_r <= 1'b0;
    end else begin
      wr_r       <= wr_nxt;
      rd_r       <= rd_nxt;
      cnt_r      <= cnt_nxt;
      head_vld_r <= head_vld_nxt;
    end
  end

endmodule

// ===== sv/tagged_string_list_parser.sv =====
// Top level of the tagged string-list parser: input register, lexer/grammar
// core and result queue. Depends on tsl_pkg, tsl_core and tsl_resq.
//
// Streaming parser for a catalogue text, one byte per input transfer, byte 0
// ending the catalogue. Each accepted byte is registered, then lexed and run
// through the group grammar in the following cycle; its results (none, one or
// two) land in a result queue of eight places behind a head output register,
// and leave one per output transfer. The first result passes the input
// register and then the head register of the queue before it is offered.
// The sustained rate is one byte per cycle as long as the output side keeps
// up; a byte that causes two results occupies the output for two transfers, and
// the input stalls whenever the queue could not absorb the worst case of two
// results for the byte in flight plus two for the next one. After an error the
// block keeps taking bytes but gives no more results until reset; after end of
// input every counter, the line counter included, returns to its reset value
// and a new catalogue may follow. Nothing needs clearing after reset.
module tagged_string_list_parser #(
  parameter int COUNT_BITS = tsl_pkg::COUNT_BITS_DEF,
  parameter int LINE_BITS  = tsl_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: one text byte per transfer.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // Result channel: one result per transfer.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_is_array,
  output logic        out_is_override,
  output logic [15:0] out_value_count,
  output logic [2:0]  out_error_code,
  output logic [23:0] out_line_number,
  output logic        out_last
);
  import tsl_pkg::*;

  logic               in_vld_r;
  logic [7:0]         in_byte_r;
  logic               in_xfer;
  push_t              push;
  res_t               head;
  logic [Q_LVL_W-1:0] level;

  // Room check: the byte in flight may add two results this edge, and a byte
  // taken now may add two more next cycle. Pops are not counted on.
  assign in_stall = in_vld_r ? (level > Q_LVL_W'(Q_DEPTH - 2 * MAX_RES))
                             : (level > Q_LVL_W'(Q_DEPTH - MAX_RES));
  assign in_xfer  = in_valid && !in_stall;

  // Input register: the core consumes it every cycle, so it never holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_byte;
    end
  end

  tsl_core #(
    .COUNT_BITS (COUNT_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_vld_r),
    .byte_in  (in_byte_r),
    .push     (push)
  );

  tsl_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_stall (out_stall),
    .out_vld   (out_valid),
    .out_res   (head),
    .level     (level)
  );

  // Drive the result fields from the queue head.
  assign out_kind        = head.kind;
  assign out_data_byte   = head.data_byte;
  assign out_is_array    = head.is_array;
  assign out_is_override = head.is_override;
  assign out_value_count = head.value_count;
  assign out_error_code  = head.error_code;
  assign out_line_number = head.line_number;
  assign out_last        = head.last;

endmodule
